/* hdl/pcfl_pkg.sv */
// ----------------------------------------------------------------------------
// pcfl_pkg
// Shared types, codes and sizing for the page color free list allocator.
// ----------------------------------------------------------------------------
package pcfl_pkg;

    localparam int MAX_COLORS = 64;
    localparam int IDX_W      = $clog2(MAX_COLORS);
    localparam int CNT_W      = $clog2(MAX_COLORS + 1);
    localparam int COLOR_W    = 6;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int WIDE_W     = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

    // total is bounded by the list depth and by the 6-bit color field
    localparam logic [CFG_W-1:0] EFF_LIMIT   = CFG_W'((MAX_COLORS < 64) ? MAX_COLORS : 64);
    localparam logic [CFG_W-1:0] TOTAL_RESET = CFG_W'(64);
    localparam logic [CFG_W-1:0] RT_RESET    = CFG_W'(32);

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RT    = 1'b1;

    localparam logic [1:0] CMD_ALLOC_DYN   = 2'd0;
    localparam logic [1:0] CMD_ALLOC_FIXED = 2'd1;
    localparam logic [1:0] CMD_FREE        = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FEW      = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic               real_time;
        logic [6:0]         alloc_count;
        logic [COLOR_W-1:0] free_color;
        logic [6:0]         batch_size;
        logic               batch_first;
    } req_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               color_valid;
        logic [1:0]         status;
        logic               last;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic       load_req;
        logic       start_range;
        logic       emit_range;
        logic       start_pop;
        logic       pop_read;
        logic       emit_pop;
        logic       do_free;
        logic       emit_single;
        logic [1:0] single_status;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] command;
        logic       rt_client;
        logic       range_empty;
        logic       pop_short;
        logic       alloc_zero;
        logic       range_last;
        logic       pop_last;
        logic       out_free;
    } dp_stat_t;

    function automatic logic [CFG_W-1:0] eff_total_of(input logic [CFG_W-1:0] total);
        return (total > EFF_LIMIT) ? EFF_LIMIT : total;
    endfunction

    function automatic logic [CFG_W-1:0] eff_rt_of(input logic [CFG_W-1:0] total,
                                                   input logic [CFG_W-1:0] rt);
        logic [CFG_W-1:0] t;
        t = eff_total_of(total);
        return (rt < t) ? rt : t;
    endfunction

endpackage

/* hdl/page_color_free_list_core.sv */
// ----------------------------------------------------------------------------
// page_color_free_list_core
// Page color allocator with a FIFO free list of real-time colors.
// ----------------------------------------------------------------------------
// One request is handled at a time; it is registered on acceptance and then
// decoded. Color ranges (best-effort, fixed real-time) then stream one result
// per cycle while the result channel does not stall; a dynamic real-time
// allocation alternates a registered read of the free list memory with the
// emit of each popped color. A free, a failure or an empty run gives a single
// result after decode. Back-pressure on the result channel stalls each result.
// Reset and every config write reload the list at once through a per-slot
// written mask, so there is no clearing pass.
module page_color_free_list_core
    import pcfl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pcfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pcfl_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* hdl/pcfl_datapath.sv */
// ----------------------------------------------------------------------------
// pcfl_datapath
// Config registers, free list memory, counters and the result register.
// ----------------------------------------------------------------------------
module pcfl_datapath
    import pcfl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  req_t                 req,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp
);

    logic [COLOR_W-1:0]    mem [MAX_COLORS];

    req_t                  req_reg,       req_next;
    logic [CFG_W-1:0]      total_reg,     total_next;
    logic [CFG_W-1:0]      rt_reg,        rt_next;
    logic [IDX_W-1:0]      head_reg,      head_next;
    logic [CNT_W-1:0]      count_reg,     count_next;
    logic                  batch_rej_reg, batch_rej_next;
    logic [MAX_COLORS-1:0] written_reg,   written_next;
    logic [CFG_W-1:0]      cursor_reg,    cursor_next;
    logic [CFG_W-1:0]      hi_reg,        hi_next;
    logic [CFG_W-1:0]      remain_reg,    remain_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg,       rsp_next;
    logic [COLOR_W-1:0]    rd_data_reg;
    logic                  rd_written_reg;
    logic [IDX_W-1:0]      rd_addr_reg;

    logic [CFG_W-1:0]      eff_total;
    logic [CFG_W-1:0]      eff_rt;
    logic [CFG_W-1:0]      range_lo;
    logic [CFG_W-1:0]      range_hi;
    logic [CNT_W:0]        push_sum;
    logic [IDX_W-1:0]      push_addr;
    logic                  push_we;
    logic                  over;
    logic                  full;
    logic                  rej;
    logic                  refill;

    assign eff_total = eff_total_of(total_reg);
    assign eff_rt    = eff_rt_of(total_reg, rt_reg);

    // real-time clients get 0..rt-1, best-effort clients rt..total-1
    assign range_lo = req_reg.real_time ? '0 : eff_rt;
    assign range_hi = req_reg.real_time ? eff_rt : eff_total;

    // tail slot, wrapped once
    assign push_sum  = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
    assign push_addr = (push_sum >= (CNT_W + 1)'(MAX_COLORS))
                     ? IDX_W'(push_sum - (CNT_W + 1)'(MAX_COLORS))
                     : IDX_W'(push_sum);

    assign over    = (WIDE_W'(count_reg) + WIDE_W'(req_reg.batch_size)) > WIDE_W'(eff_total);
    assign full    = (count_reg == CNT_W'(MAX_COLORS));
    assign rej     = req_reg.batch_first ? over : batch_rej_reg;
    assign push_we = cmd.do_free && !rej && !full;
    assign refill  = cfg_we && (cfg_index == CFG_TOTAL || cfg_index == CFG_RT);

    always_comb
    begin
        req_next       = req_reg;
        total_next     = total_reg;
        rt_next        = rt_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        batch_rej_next = batch_rej_reg;
        written_next   = written_reg;
        cursor_next    = cursor_reg;
        hi_next        = hi_reg;
        remain_next    = remain_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        if (cmd.load_req)
        begin
            req_next = req;
        end

        if (cmd.start_range)
        begin
            cursor_next = range_lo;
            hi_next     = range_hi;
        end

        if (cmd.emit_range)
        begin
            rsp_next.color       = COLOR_W'(cursor_reg);
            rsp_next.color_valid = 1'b1;
            rsp_next.status      = STATUS_OK;
            rsp_next.last        = stat.range_last;
            rsp_valid_next       = 1'b1;
            cursor_next          = cursor_reg + CFG_W'(1);
        end

        if (cmd.start_pop)
        begin
            remain_next = req_reg.alloc_count;
        end

        if (cmd.emit_pop)
        begin
            // slots untouched since the last refill still hold their own index
            rsp_next.color       = rd_written_reg ? rd_data_reg : COLOR_W'(rd_addr_reg);
            rsp_next.color_valid = 1'b1;
            rsp_next.status      = STATUS_OK;
            rsp_next.last        = stat.pop_last;
            rsp_valid_next       = 1'b1;
            head_next            = (head_reg == IDX_W'(MAX_COLORS - 1))
                                 ? '0 : head_reg + IDX_W'(1);
            count_next           = count_reg - CNT_W'(1);
            remain_next          = remain_reg - CFG_W'(1);
        end

        if (cmd.do_free)
        begin
            batch_rej_next       = rej;
            rsp_next.color       = '0;
            rsp_next.color_valid = 1'b0;
            rsp_next.status      = push_we ? STATUS_OK : STATUS_OVERFLOW;
            rsp_next.last        = 1'b1;
            rsp_valid_next       = 1'b1;
            if (push_we)
            begin
                count_next              = count_reg + CNT_W'(1);
                written_next[push_addr] = 1'b1;
            end
        end

        if (cmd.emit_single)
        begin
            rsp_next.color       = '0;
            rsp_next.color_valid = 1'b0;
            rsp_next.status      = cmd.single_status;
            rsp_next.last        = 1'b1;
            rsp_valid_next       = 1'b1;
        end

        if (refill)
        begin
            if (cfg_index == CFG_TOTAL)
            begin
                total_next = cfg_data;
            end
            else
            begin
                rt_next = cfg_data;
            end
            head_next      = '0;
            count_next     = CNT_W'(eff_rt_of(total_next, rt_next));
            batch_rej_next = 1'b0;
            written_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= TOTAL_RESET;
            rt_reg        <= RT_RESET;
            head_reg      <= '0;
            count_reg     <= CNT_W'(eff_rt_of(TOTAL_RESET, RT_RESET));
            batch_rej_reg <= 1'b0;
            written_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            rt_reg        <= rt_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            batch_rej_reg <= batch_rej_next;
            written_reg   <= written_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        cursor_reg <= cursor_next;
        hi_reg     <= hi_next;
        remain_reg <= remain_next;
        rsp_reg    <= rsp_next;
    end

    // free list memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (push_we)
        begin
            mem[push_addr] <= req_reg.free_color;
        end
        if (cmd.pop_read)
        begin
            rd_data_reg    <= mem[head_reg];
            rd_written_reg <= written_reg[head_reg];
            rd_addr_reg    <= head_reg;
        end
    end

    always_comb
    begin
        stat.command     = req_reg.command;
        stat.rt_client   = req_reg.real_time;
        stat.range_empty = (range_lo >= range_hi);
        stat.pop_short   = WIDE_W'(count_reg) < WIDE_W'(req_reg.alloc_count);
        stat.alloc_zero  = (req_reg.alloc_count == '0);
        stat.range_last  = ((cursor_reg + CFG_W'(1)) == hi_reg);
        stat.pop_last    = (remain_reg == CFG_W'(1));
        stat.out_free    = !rsp_valid_reg || rsp_ready;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* hdl/pcfl_ctrl.sv */
// ----------------------------------------------------------------------------
// pcfl_ctrl
// Sequencer: decodes a request and steps the datapath through its results.
// ----------------------------------------------------------------------------
module pcfl_ctrl
    import pcfl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RANGE,
        ST_POP_RD,
        ST_POP_EMIT,
        ST_FREE,
        ST_SINGLE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] single_status_reg, single_status_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next         = state_reg;
        single_status_next = single_status_reg;
        cmd                = '0;
        cmd.single_status  = single_status_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                single_status_next = STATUS_OK;
                case (stat.command)
                    CMD_ALLOC_DYN, CMD_ALLOC_FIXED:
                    begin
                        if (!stat.rt_client || stat.command == CMD_ALLOC_FIXED)
                        begin
                            if (stat.range_empty)
                            begin
                                state_next = ST_SINGLE;
                            end
                            else
                            begin
                                cmd.start_range = 1'b1;
                                state_next      = ST_RANGE;
                            end
                        end
                        else if (stat.pop_short)
                        begin
                            single_status_next = STATUS_FEW;
                            state_next         = ST_SINGLE;
                        end
                        else if (stat.alloc_zero)
                        begin
                            state_next = ST_SINGLE;
                        end
                        else
                        begin
                            cmd.start_pop = 1'b1;
                            state_next    = ST_POP_RD;
                        end
                    end
                    CMD_FREE:
                    begin
                        state_next = ST_FREE;
                    end
                    default:
                    begin
                        state_next = ST_SINGLE;
                    end
                endcase
            end

            ST_RANGE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_range = 1'b1;
                    if (stat.range_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_POP_RD:
            begin
                cmd.pop_read = 1'b1;
                state_next   = ST_POP_EMIT;
            end

            ST_POP_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_pop = 1'b1;
                    state_next   = stat.pop_last ? ST_IDLE : ST_POP_RD;
                end
            end

            ST_FREE:
            begin
                if (stat.out_free)
                begin
                    cmd.do_free = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_SINGLE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_single = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            single_status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg         <= state_next;
            single_status_reg <= single_status_next;
        end
    end

endmodule

/* hdl/pcfl_checker.sv */
// ----------------------------------------------------------------------------
// pcfl_checker
// Port-level checks for the page color allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pcfl_checker
    import pcfl_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.color_valid |-> rsp.last)
        else $error("empty result not marked last");

    a_empty_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.color_valid |-> rsp.color == '0)
        else $error("empty result carries a color");

    a_fail_no_color: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != STATUS_OK |-> !rsp.color_valid)
        else $error("failed result carries a color");

endmodule

bind page_color_free_list_core pcfl_checker u_pcfl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

/* dv/grant_checker.sv */
// ----------------------------------------------------------------------------
// grant_checker
// Watches the request, result and register ports of the page color allocator,
// keeps its own copy of the free list, and compares every result with the
// oldest predicted grant.
// ----------------------------------------------------------------------------
module grant_checker
    import pcfl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_ready,
    input  req_t                 req,
    input  logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   pending_grants,
    output int                   requests_seen,
    output int                   grants_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLOR_CAP   = 64;   // 6-bit color field
    localparam int PRINT_LIMIT = 40;

    logic [CFG_W-1:0]   total_reg;
    logic [CFG_W-1:0]   rt_reg;
    logic [COLOR_W-1:0] free_ring [MAX_COLORS];
    int                 ring_head;
    int                 ring_count;
    logic               batch_dropped;
    rsp_t               grant_q [$];

    function automatic int usable_total();
        int t;
        t = total_reg;
        if (t > MAX_COLORS)
            t = MAX_COLORS;
        if (t > COLOR_CAP)
            t = COLOR_CAP;
        return t;
    endfunction

    function automatic int usable_rt();
        int t;
        t = usable_total();
        return (int'(rt_reg) < t) ? int'(rt_reg) : t;
    endfunction

    // list goes back to 0..rt-1 in order, batch state cleared
    task automatic reload_ring();
        int rt;
        rt = usable_rt();
        for (int i = 0; i < MAX_COLORS; i++)
            free_ring[i] = (i < rt) ? COLOR_W'(i) : '0;
        ring_head     = 0;
        ring_count    = rt;
        batch_dropped = 1'b0;
    endtask

    task automatic push_grant(input int color, input logic valid, input logic [1:0] status,
                              input logic last);
        rsp_t g;
        g.color       = COLOR_W'(color);
        g.color_valid = valid;
        g.status      = status;
        g.last        = last;
        grant_q = {grant_q, g};
    endtask

    task automatic push_color_run(input int lo, input int hi);
        if (lo >= hi)
            push_grant(0, 1'b0, STATUS_OK, 1'b1);
        else
            for (int c = lo; c < hi; c++)
                push_grant(c, 1'b1, STATUS_OK, c == hi - 1);
    endtask

    task automatic predict_grants(input req_t r);
        int n;
        n = r.alloc_count;
        case (r.command)
            CMD_ALLOC_DYN, CMD_ALLOC_FIXED:
            begin
                if (!r.real_time)
                    push_color_run(usable_rt(), usable_total());
                else if (r.command == CMD_ALLOC_FIXED)
                    push_color_run(0, usable_rt());
                else if (ring_count < n)
                    push_grant(0, 1'b0, STATUS_FEW, 1'b1);
                else if (n == 0)
                    push_grant(0, 1'b0, STATUS_OK, 1'b1);
                else
                    for (int i = 0; i < n; i++)
                    begin
                        push_grant(free_ring[ring_head], 1'b1, STATUS_OK, i == n - 1);
                        ring_head = (ring_head + 1) % MAX_COLORS;
                        ring_count--;
                    end
            end
            CMD_FREE:
            begin
                // the size check runs only on the first item of a batch
                if (r.batch_first)
                    batch_dropped = (ring_count + int'(r.batch_size)) > usable_total();
                if (batch_dropped || ring_count >= MAX_COLORS)
                    push_grant(0, 1'b0, STATUS_OVERFLOW, 1'b1);
                else
                begin
                    free_ring[(ring_head + ring_count) % MAX_COLORS] = r.free_color;
                    ring_count++;
                    push_grant(0, 1'b0, STATUS_OK, 1'b1);
                end
            end
            default:
                push_grant(0, 1'b0, STATUS_OK, 1'b1);
        endcase
    endtask

    task automatic note_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] grant_checker: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_grant(input rsp_t got);
        rsp_t want;
        if (grant_q.size() == 0)
        begin
            note_mismatch($sformatf("unexpected result color=%0d valid=%0b status=%0d last=%0b",
                                    got.color, got.color_valid, got.status, got.last));
            return;
        end
        want = grant_q.pop_front();
        if (got.color !== want.color)
            note_mismatch($sformatf("color %0d, expected %0d", got.color, want.color));
        if (got.color_valid !== want.color_valid)
            note_mismatch($sformatf("color_valid %0b, expected %0b",
                                    got.color_valid, want.color_valid));
        if (got.status !== want.status)
            note_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.last !== want.last)
            note_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg = TOTAL_RESET;
            rt_reg    = RT_RESET;
            reload_ring();
            grant_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TOTAL)
                    total_reg = cfg_data;
                else if (cfg_index == CFG_RT)
                    rt_reg = cfg_data;
                reload_ring();
            end
            if (req_valid && req_ready)
            begin
                predict_grants(req);
                requests_seen++;
            end
            if (rsp_valid && rsp_ready)
            begin
                check_grant(rsp);
                grants_seen++;
            end
        end
        pending_grants = grant_q.size();
    end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the page color allocator with directed corner requests and then
// phases of random allocate/return traffic under several register settings,
// with random gaps and stalls on both channels and two long result stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pcfl_pkg::*;

    localparam int         CLK_PERIOD   = 8;
    localparam int         RESET_CYCLES = 2;
    localparam int         CYCLE_LIMIT  = 2_000_000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         HOLD_OFF     = 300;
    localparam int         PHASES       = 10;
    localparam int         PHASE_ITEMS  = 33;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req       = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int mismatches;
    int pending_grants;
    int requests_seen;
    int grants_seen;
    int cycles        = 0;
    int sent          = 0;
    int settings_used = 1;
    bit send_calm     = 1'b0;

    // register settings for the random phases, extremes first
    int total_table [8] = '{64, 64, 1, 1, 127, 0, 100, 10};
    int rt_table    [8] = '{64,  0, 1, 0, 127, 9,  40, 60};

    always #(CLK_PERIOD / 2) clk = ~clk;

    page_color_free_list_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    grant_checker grant_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending_grants (pending_grants),
        .requests_seen  (requests_seen),
        .grants_seen    (grants_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_top: timed out after %0d cycles", cycles);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic req_t make_req(input logic [1:0] cmd, input int rt_client,
                                      input int count, input int color, input int size,
                                      input int first);
        req_t r;
        r.command     = cmd;
        r.real_time   = rt_client[0];
        r.alloc_count = count[6:0];
        r.free_color  = color[COLOR_W-1:0];
        r.batch_size  = size[6:0];
        r.batch_first = first[0];
        return r;
    endfunction

    task automatic issue_request(input req_t r);
        int gap;
        if (sent % 24 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
        gap = send_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        sent++;
    endtask

    // wait until every predicted grant has come back and the block is quiet
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_grants != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_colors(input int total, input int rt);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TOTAL;
        cfg_data  <= total[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_RT;
        cfg_data  <= rt[CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    task automatic random_phase(input int budget);
        int start;
        int kind;
        int n;
        int declared;
        start = sent;
        while (sent - start < budget)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                // take n real-time colors, then hand n colors back as one batch
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 6);
                issue_request(make_req(CMD_ALLOC_DYN, 1, n, $urandom_range(0, 63),
                                       $urandom_range(0, 127), $urandom_range(0, 1)));
                for (int i = 0; i < n; i++)
                    issue_request(make_req(CMD_FREE, $urandom_range(0, 1),
                                           $urandom_range(0, 127), $urandom_range(0, 63),
                                           n, i == 0));
            end
            else if (kind < 55)
                issue_request(make_req(2'($urandom_range(0, 1)), $urandom_range(0, 1),
                                       $urandom_range(0, 127), $urandom_range(0, 63),
                                       $urandom_range(0, 127), $urandom_range(0, 1)));
            else if (kind < 68)
            begin
                // free batch, sometimes with a size that does not match its length
                n = $urandom_range(1, 8);
                declared = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : n;
                for (int i = 0; i < n; i++)
                    issue_request(make_req(CMD_FREE, $urandom_range(0, 1),
                                           $urandom_range(0, 127), $urandom_range(0, 63),
                                           declared, i == 0));
            end
            else if (kind < 80)
                issue_request(make_req(CMD_ALLOC_DYN, 1, $urandom_range(0, 127),
                                       $urandom_range(0, 63), $urandom_range(0, 127),
                                       $urandom_range(0, 1)));
            else if (kind < 90)
                issue_request(make_req(CMD_FREE, $urandom_range(0, 1), $urandom_range(0, 127),
                                       $urandom_range(0, 63), $urandom_range(0, 127),
                                       $urandom_range(0, 1)));
            else
                issue_request(make_req(CMD_UNUSED, $urandom_range(0, 1),
                                       $urandom_range(0, 127), $urandom_range(0, 63),
                                       $urandom_range(0, 127), $urandom_range(0, 1)));
        end
    endtask

    // result side: random stalls, calm stretches, and two long hold-offs
    initial
    begin : result_drain
        int stall;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 32 == 0)
                calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, 12);
            if (taken == 150 || taken == 2500)
                stall = HOLD_OFF;
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            taken++;
        end
    end

    initial
    begin : request_source
        int total;
        int rt;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: total 64, list holds 0..31
        issue_request(make_req(CMD_ALLOC_DYN,   1,   0,  0,   0, 0));  // zero-count alloc
        issue_request(make_req(CMD_ALLOC_DYN,   1,   1,  0,   0, 0));  // pops color 0
        issue_request(make_req(CMD_ALLOC_DYN,   1,  64,  0,   0, 0));  // too few free
        issue_request(make_req(CMD_ALLOC_DYN,   1, 127, 63, 127, 1));  // too few, fields high
        issue_request(make_req(CMD_ALLOC_FIXED, 1,   0,  0,   0, 0));  // fixed real-time run
        issue_request(make_req(CMD_ALLOC_DYN,   0,   5,  0,   0, 0));  // best-effort run
        issue_request(make_req(CMD_ALLOC_FIXED, 0,   0,  0,   0, 0));
        issue_request(make_req(CMD_FREE,        0,   0,  7,  64, 1));  // batch too big
        issue_request(make_req(CMD_FREE,        0,   0,  8,  64, 0));  // rest of dropped batch
        issue_request(make_req(CMD_FREE,        1, 127, 63,   1, 1));
        issue_request(make_req(CMD_FREE,        0,   0,  0, 127, 1));  // largest batch size
        issue_request(make_req(CMD_FREE,        0,   0, 42,   0, 1));  // empty batch passes
        issue_request(make_req(CMD_ALLOC_DYN,   1,  33,  0,   0, 0));  // drains the list
        issue_request(make_req(CMD_ALLOC_DYN,   1,   1,  0,   0, 0));  // list empty
        issue_request(make_req(CMD_UNUSED,      1, 127, 63, 127, 1));
        issue_request(make_req(CMD_UNUSED,      0,   0,  0,   0, 0));

        // full list: every color real-time
        settle();
        program_colors(64, 64);
        issue_request(make_req(CMD_FREE,        0,   0,  5,   0, 0));  // list full
        issue_request(make_req(CMD_FREE,        0,   0,  6,   0, 1));  // check passes, full
        issue_request(make_req(CMD_ALLOC_DYN,   0,   0,  0,   0, 0));  // empty best-effort run
        issue_request(make_req(CMD_ALLOC_DYN,   1,  64,  0,   0, 0));  // pops whole list
        issue_request(make_req(CMD_FREE,        0,   0,  9,  64, 1));

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 8)
            begin
                total = total_table[p];
                rt    = rt_table[p];
            end
            else
            begin
                total = $urandom_range(1, 64);
                rt    = $urandom_range(0, 64);
            end
            settle();
            program_colors(total, rt);
            random_phase(PHASE_ITEMS);
        end
        settle();

        $display("tb_top: %0d requests and %0d results checked over %0d register settings",
                 requests_seen, grants_seen, settings_used);
        $display("tb_top: %0d mismatches, %0d cycles", mismatches, cycles);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* sim.f */
hdl/pcfl_pkg.sv
hdl/pcfl_datapath.sv
hdl/pcfl_ctrl.sv
hdl/page_color_free_list_core.sv
hdl/pcfl_checker.sv
dv/grant_checker.sv
dv/tb_top.sv
